// ===== design/pts_pkg.sv =====
// ----------------------------------------------------------------------------
// pts_pkg : shared types and constants of the priority task scheduler
// Task status and event codes, command codes, the per-slot table entry,
// the sequencer states and the request format of the shared ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package pts_pkg;

    // Per-slot task status
    typedef enum logic [2:0] {
        ST_EMPTY = 3'd0,
        ST_READY = 3'd1,
        ST_RUN   = 3'd2,
        ST_BLOCK = 3'd3,
        ST_DONE  = 3'd4
    } t_status;

    // Event code carried by each result transfer
    typedef enum logic [2:0] {
        EV_NONE  = 3'd0,
        EV_ADD   = 3'd1,
        EV_DISP  = 3'd2,
        EV_REQ   = 3'd3,
        EV_FIN   = 3'd4,
        EV_BLK   = 3'd5,
        EV_UNBLK = 3'd6,
        EV_REJ   = 3'd7
    } t_event;

    // Command codes
    typedef enum logic [1:0] {
        FN_ADD     = 2'd0,
        FN_TICK    = 2'd1,
        FN_BLOCK   = 2'd2,
        FN_UNBLOCK = 2'd3
    } t_func;

    // Shared ALU operations
    typedef enum logic [1:0] {
        ALU_GT      = 2'd0,
        ALU_SUB     = 2'd1,
        ALU_ADD_SAT = 2'd2
    } t_alu_op;

    typedef struct packed {
        t_alu_op     op;
        logic [31:0] a;
        logic [31:0] b;
    } t_alu_req;

    // One row of the task table
    typedef struct packed {
        logic [7:0]  prio;
        logic [15:0] work_total;
        logic [15:0] work_done;
        logic [15:0] runs;
        logic [31:0] wait_sum;
        logic [31:0] last_disp;
    } t_entry;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOK,
        S_EXEC,
        S_CHK,
        S_SCAN,
        S_DREAD,
        S_DSUB,
        S_DADD,
        S_DWRITE,
        S_EMIT1,
        S_EMIT2,
        S_ZREAD,
        S_ZEMIT
    } t_state;

    localparam logic [7:0]  SLICE_RESET = 8'd5;
    localparam logic [7:0]  SLICE_MAX   = 8'hFF;
    localparam logic [15:0] RUNS_MAX    = 16'hFFFF;
    localparam logic [31:0] CNT_MAX     = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

// ===== design/pts_ram.sv =====
// ----------------------------------------------------------------------------
// pts_ram : generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== design/pts_alu.sv =====
// ----------------------------------------------------------------------------
// pts_alu : shared 32-bit arithmetic unit of the scheduler
// Priority compare during the scan, wrapped subtract and saturating add
// for the wait accounting of a dispatch.
// ----------------------------------------------------------------------------
`default_nettype none

module pts_alu (
    input  wire pts_pkg::t_alu_req i_req,
    output logic [31:0]            o_y
);

    logic [32:0] w_sum;

    assign w_sum = {1'b0, i_req.a} + {1'b0, i_req.b};

    always_comb begin
        case (i_req.op)
            pts_pkg::ALU_GT:      o_y = {31'd0, (i_req.a > i_req.b)};
            pts_pkg::ALU_SUB:     o_y = i_req.a - i_req.b;
            pts_pkg::ALU_ADD_SAT: o_y = w_sum[32] ? pts_pkg::CNT_MAX : w_sum[31:0];
            default:              o_y = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// ===== design/priority_task_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// priority_task_scheduler_top : fixed-priority time-sliced task scheduler
// Command-driven task table with dispatch scan, slice timer and statistics.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; busy then stays
// high until its last result has been launched, and that result sits on the
// result ports in the first cycle with busy low. Each command yields one or
// two result transfers, each on the result ports for a single cycle marked by
// o_strobe, with o_last on the final one; the receiver cannot stall them.
// When the running slot is free after the command, a dispatch scan reads the
// task table one slot per cycle through the single read port of the table RAM.
// slice_ticks is written through the cfg channel while busy is low.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_task_scheduler_top #(
    parameter int NUM_TASKS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // command channel
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_func,
    input  wire logic [3:0]  i_task_id,
    input  wire logic [7:0]  i_priority_req,
    input  wire logic [15:0] i_work_ticks,
    // result channel
    output logic             o_strobe,
    output logic [2:0]       o_event_res,
    output logic [3:0]       o_task_id_out,
    output logic [15:0]      o_run_count,
    output logic [31:0]      o_wait_total,
    output logic [31:0]      o_context_switches,
    output logic             o_last,
    // configuration channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_data
);

    localparam int SLOT_W = $clog2(NUM_TASKS);
    localparam int SCAN_W = $clog2(NUM_TASKS + 1);
    localparam int ENT_W  = $bits(pts_pkg::t_entry);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_TASKS - 1);

    // control registers
    pts_pkg::t_state  r_state, n_state;
    pts_pkg::t_status r_status [NUM_TASKS];
    pts_pkg::t_status n_status [NUM_TASKS];
    logic [7:0]        r_slice_ticks, n_slice_ticks;
    logic [31:0]       r_tick, n_tick;
    logic [SLOT_W-1:0] r_run_slot, n_run_slot;
    logic              r_run_valid, n_run_valid;
    logic [7:0]        r_slice_cnt, n_slice_cnt;
    logic [31:0]       r_switch, n_switch;
    logic [SCAN_W-1:0] r_scan, n_scan;
    logic              r_cmp_valid, n_cmp_valid;
    logic              r_best_valid, n_best_valid;
    logic              r_disp, n_disp;
    logic              r_strobe, n_strobe;

    // payload registers
    pts_pkg::t_func    r_func, n_func;
    logic [3:0]        r_id, n_id;
    logic [7:0]        r_prio, n_prio;
    logic [15:0]       r_work, n_work;
    pts_pkg::t_event   r_pend_ev, n_pend_ev;
    logic [3:0]        r_pend_id, n_pend_id;
    logic [15:0]       r_pend_runs, n_pend_runs;
    logic [31:0]       r_pend_wait, n_pend_wait;
    logic [31:0]       r_pend_sw, n_pend_sw;
    logic [SLOT_W-1:0] r_cmp_idx, n_cmp_idx;
    logic [SLOT_W-1:0] r_best, n_best;
    logic [7:0]        r_best_prio, n_best_prio;
    pts_pkg::t_entry   r_ent, n_ent;
    logic [31:0]       r_acc, n_acc;
    logic [15:0]       r_disp_runs, n_disp_runs;
    logic [31:0]       r_disp_wait, n_disp_wait;
    pts_pkg::t_event   r_out_ev, n_out_ev;
    logic [3:0]        r_out_id, n_out_id;
    logic [15:0]       r_out_runs, n_out_runs;
    logic [31:0]       r_out_wait, n_out_wait;
    logic [31:0]       r_out_sw, n_out_sw;
    logic              r_out_last, n_out_last;

    // table RAM and ALU
    logic              w_we;
    logic [SLOT_W-1:0] w_waddr, w_raddr;
    pts_pkg::t_entry   w_wdata;
    logic [ENT_W-1:0]  w_rdata;
    pts_pkg::t_entry   w_ent;
    pts_pkg::t_alu_req w_alu_req;
    logic [31:0]       w_alu_y;

    // lookups
    logic              w_in_range;
    logic [SLOT_W-1:0] w_id_slot, w_look_slot;
    pts_pkg::t_status  w_look_st, w_cmp_st, w_zero_st;
    logic              w_take;

    pts_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NUM_TASKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    pts_alu u_alu (
        .i_req (w_alu_req),
        .o_y   (w_alu_y)
    );

    assign w_ent = pts_pkg::t_entry'(w_rdata);

    // slot named by the command, and the slot whose row the command needs
    assign w_in_range  = (32'(r_id) < NUM_TASKS);
    assign w_id_slot   = w_in_range ? SLOT_W'(r_id) : '0;
    assign w_look_slot = (r_func == pts_pkg::FN_ADD || r_func == pts_pkg::FN_UNBLOCK)
                         ? w_id_slot : r_run_slot;
    assign w_look_st   = r_status[w_look_slot];
    assign w_cmp_st    = r_status[r_cmp_idx];
    assign w_zero_st   = r_status[0];

    // scan: ready task that beats the best so far (strictly, so low id wins ties)
    assign w_take = r_cmp_valid && (w_cmp_st == pts_pkg::ST_READY) &&
                    (!r_best_valid || w_alu_y[0]);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pts_pkg::S_IDLE:   if (start) n_state = pts_pkg::S_LOOK;
            pts_pkg::S_LOOK:   n_state = pts_pkg::S_EXEC;
            pts_pkg::S_EXEC:   n_state = pts_pkg::S_CHK;
            pts_pkg::S_CHK:    n_state = r_run_valid ? pts_pkg::S_EMIT1 : pts_pkg::S_SCAN;
            pts_pkg::S_SCAN: begin
                if (r_cmp_valid && r_cmp_idx == LAST_SLOT) begin
                    n_state = (r_best_valid || w_take) ? pts_pkg::S_DREAD
                                                       : pts_pkg::S_EMIT1;
                end
            end
            pts_pkg::S_DREAD:  n_state = pts_pkg::S_DSUB;
            pts_pkg::S_DSUB:   n_state = pts_pkg::S_DADD;
            pts_pkg::S_DADD:   n_state = pts_pkg::S_DWRITE;
            pts_pkg::S_DWRITE: n_state = pts_pkg::S_EMIT1;
            pts_pkg::S_EMIT1: begin
                if (r_disp) begin
                    n_state = pts_pkg::S_EMIT2;
                end else if (r_pend_ev != pts_pkg::EV_NONE) begin
                    n_state = pts_pkg::S_IDLE;
                end else begin
                    n_state = pts_pkg::S_ZREAD;
                end
            end
            pts_pkg::S_EMIT2:  n_state = pts_pkg::S_IDLE;
            pts_pkg::S_ZREAD:  n_state = pts_pkg::S_ZEMIT;
            pts_pkg::S_ZEMIT:  n_state = pts_pkg::S_IDLE;
            default:           n_state = pts_pkg::S_IDLE;
        endcase
    end

    // datapath control per state
    always_comb begin
        logic [15:0]     v_done;
        logic [7:0]      v_slice;
        logic [7:0]      v_len;
        logic [15:0]     v_runs;
        logic [31:0]     v_wait;
        logic            v_occ;
        pts_pkg::t_entry v_ent;

        n_status      = r_status;
        n_slice_ticks = r_slice_ticks;
        n_tick        = r_tick;
        n_run_slot    = r_run_slot;
        n_run_valid   = r_run_valid;
        n_slice_cnt   = r_slice_cnt;
        n_switch      = r_switch;
        n_scan        = r_scan;
        n_cmp_valid   = r_cmp_valid;
        n_best_valid  = r_best_valid;
        n_disp        = r_disp;
        n_strobe      = 1'b0;
        n_func        = r_func;
        n_id          = r_id;
        n_prio        = r_prio;
        n_work        = r_work;
        n_pend_ev     = r_pend_ev;
        n_pend_id     = r_pend_id;
        n_pend_runs   = r_pend_runs;
        n_pend_wait   = r_pend_wait;
        n_pend_sw     = r_pend_sw;
        n_cmp_idx     = r_cmp_idx;
        n_best        = r_best;
        n_best_prio   = r_best_prio;
        n_ent         = r_ent;
        n_acc         = r_acc;
        n_disp_runs   = r_disp_runs;
        n_disp_wait   = r_disp_wait;
        n_out_ev      = r_out_ev;
        n_out_id      = r_out_id;
        n_out_runs    = r_out_runs;
        n_out_wait    = r_out_wait;
        n_out_sw      = r_out_sw;
        n_out_last    = r_out_last;

        w_we      = 1'b0;
        w_waddr   = '0;
        w_wdata   = '0;
        w_raddr   = '0;
        w_alu_req = '{op: pts_pkg::ALU_GT, a: 32'(w_ent.prio), b: 32'(r_best_prio)};

        v_done  = w_ent.work_done;
        v_slice = r_slice_cnt;
        v_len   = (r_slice_ticks == 8'd0) ? 8'd1 : r_slice_ticks;
        v_runs  = r_ent.runs;
        v_wait  = r_ent.wait_sum;
        v_occ   = w_look_st != pts_pkg::ST_EMPTY;
        v_ent   = w_ent;

        // configuration transfer
        if (i_cfg_valid && o_cfg_ready) begin
            n_slice_ticks = i_cfg_data;
        end

        case (r_state)
            pts_pkg::S_IDLE: begin
                if (start) begin
                    n_func = pts_pkg::t_func'(i_func);
                    n_id   = i_task_id;
                    n_prio = i_priority_req;
                    n_work = i_work_ticks;
                    n_disp = 1'b0;
                end
            end

            pts_pkg::S_LOOK: begin
                w_raddr = w_look_slot;
            end

            // carry out the command on the row just read
            pts_pkg::S_EXEC: begin
                n_pend_sw   = r_switch;
                n_pend_ev   = pts_pkg::EV_REJ;
                n_pend_id   = r_id;
                n_pend_runs = v_occ ? w_ent.runs : 16'd0;
                n_pend_wait = v_occ ? w_ent.wait_sum : 32'd0;
                case (r_func)
                    pts_pkg::FN_ADD: begin
                        if (!w_in_range) begin
                            n_pend_runs = 16'd0;
                            n_pend_wait = 32'd0;
                        end else if (!v_occ) begin
                            w_we    = 1'b1;
                            w_waddr = w_id_slot;
                            w_wdata = '{prio: r_prio, work_total: r_work,
                                        work_done: 16'd0, runs: 16'd0,
                                        wait_sum: 32'd0, last_disp: r_tick};
                            n_status[w_id_slot] = pts_pkg::ST_READY;
                            n_pend_ev   = pts_pkg::EV_ADD;
                            n_pend_runs = 16'd0;
                            n_pend_wait = 32'd0;
                        end
                    end
                    pts_pkg::FN_TICK: begin
                        n_tick    = r_tick + 32'd1;
                        n_pend_ev = pts_pkg::EV_NONE;
                        n_pend_id = 4'd0;
                        if (r_run_valid) begin
                            if (w_ent.work_done < w_ent.work_total) begin
                                v_done = w_ent.work_done + 16'd1;
                            end
                            if (r_slice_cnt != pts_pkg::SLICE_MAX) begin
                                v_slice = r_slice_cnt + 8'd1;
                            end
                            n_slice_cnt     = v_slice;
                            v_ent.work_done = v_done;
                            w_we    = 1'b1;
                            w_waddr = r_run_slot;
                            w_wdata = v_ent;
                            if (v_done >= w_ent.work_total) begin
                                n_status[r_run_slot] = pts_pkg::ST_DONE;
                                n_run_valid = 1'b0;
                                n_pend_ev   = pts_pkg::EV_FIN;
                                n_pend_id   = 4'(r_run_slot);
                            end else if (v_slice >= v_len) begin
                                n_status[r_run_slot] = pts_pkg::ST_READY;
                                n_run_valid = 1'b0;
                                n_pend_ev   = pts_pkg::EV_REQ;
                                n_pend_id   = 4'(r_run_slot);
                            end
                        end
                    end
                    pts_pkg::FN_BLOCK: begin
                        n_pend_id = 4'(r_run_slot);
                        if (r_run_valid) begin
                            n_status[r_run_slot] = pts_pkg::ST_BLOCK;
                            n_run_valid = 1'b0;
                            n_pend_ev   = pts_pkg::EV_BLK;
                        end
                    end
                    pts_pkg::FN_UNBLOCK: begin
                        if (!w_in_range) begin
                            n_pend_runs = 16'd0;
                            n_pend_wait = 32'd0;
                        end else if (w_look_st == pts_pkg::ST_BLOCK) begin
                            n_status[w_id_slot] = pts_pkg::ST_READY;
                            n_pend_ev = pts_pkg::EV_UNBLK;
                        end
                    end
                    default: ;
                endcase
            end

            pts_pkg::S_CHK: begin
                n_scan       = '0;
                n_cmp_valid  = 1'b0;
                n_best_valid = 1'b0;
            end

            // one slot read per cycle, compared in the cycle after
            pts_pkg::S_SCAN: begin
                if (r_scan < SCAN_W'(NUM_TASKS)) begin
                    w_raddr     = r_scan[SLOT_W-1:0];
                    n_scan      = r_scan + SCAN_W'(1);
                    n_cmp_valid = 1'b1;
                    n_cmp_idx   = r_scan[SLOT_W-1:0];
                end else begin
                    n_cmp_valid = 1'b0;
                end
                if (w_take) begin
                    n_best_valid = 1'b1;
                    n_best       = r_cmp_idx;
                    n_best_prio  = w_ent.prio;
                end
            end

            pts_pkg::S_DREAD: begin
                w_raddr = r_best;
            end

            // wrapped time since the last dispatch
            pts_pkg::S_DSUB: begin
                n_ent     = w_ent;
                w_alu_req = '{op: pts_pkg::ALU_SUB, a: r_tick, b: w_ent.last_disp};
                n_acc     = w_alu_y;
            end

            pts_pkg::S_DADD: begin
                w_alu_req = '{op: pts_pkg::ALU_ADD_SAT, a: r_ent.wait_sum, b: r_acc};
                n_acc     = w_alu_y;
            end

            pts_pkg::S_DWRITE: begin
                if (r_ent.runs != 16'd0) begin
                    v_wait = r_acc;
                end
                if (r_ent.runs != pts_pkg::RUNS_MAX) begin
                    v_runs = r_ent.runs + 16'd1;
                end
                v_ent           = r_ent;
                v_ent.runs      = v_runs;
                v_ent.wait_sum  = v_wait;
                v_ent.last_disp = r_tick;
                w_we    = 1'b1;
                w_waddr = r_best;
                w_wdata = v_ent;
                n_status[r_best] = pts_pkg::ST_RUN;
                n_run_slot  = r_best;
                n_run_valid = 1'b1;
                n_slice_cnt = 8'd0;
                if (r_switch != pts_pkg::CNT_MAX) begin
                    n_switch = r_switch + 32'd1;
                end
                n_disp      = 1'b1;
                n_disp_runs = v_runs;
                n_disp_wait = v_wait;
            end

            pts_pkg::S_EMIT1: begin
                if (r_pend_ev != pts_pkg::EV_NONE) begin
                    n_strobe   = 1'b1;
                    n_out_ev   = r_pend_ev;
                    n_out_id   = r_pend_id;
                    n_out_runs = r_pend_runs;
                    n_out_wait = r_pend_wait;
                    n_out_sw   = r_pend_sw;
                    n_out_last = !r_disp;
                end
            end

            pts_pkg::S_EMIT2: begin
                n_strobe   = 1'b1;
                n_out_ev   = pts_pkg::EV_DISP;
                n_out_id   = 4'(r_best);
                n_out_runs = r_disp_runs;
                n_out_wait = r_disp_wait;
                n_out_sw   = r_switch;
                n_out_last = 1'b1;
            end

            pts_pkg::S_ZREAD: begin
                w_raddr = '0;
            end

            // nothing to report: slot zero's statistics
            pts_pkg::S_ZEMIT: begin
                n_strobe   = 1'b1;
                n_out_ev   = pts_pkg::EV_NONE;
                n_out_id   = 4'd0;
                n_out_runs = (w_zero_st != pts_pkg::ST_EMPTY) ? w_ent.runs : 16'd0;
                n_out_wait = (w_zero_st != pts_pkg::ST_EMPTY) ? w_ent.wait_sum : 32'd0;
                n_out_sw   = r_switch;
                n_out_last = 1'b1;
            end

            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= pts_pkg::S_IDLE;
            r_slice_ticks <= pts_pkg::SLICE_RESET;
            r_tick        <= 32'd0;
            r_run_slot    <= '0;
            r_run_valid   <= 1'b0;
            r_slice_cnt   <= 8'd0;
            r_switch      <= 32'd0;
            r_scan        <= '0;
            r_cmp_valid   <= 1'b0;
            r_best_valid  <= 1'b0;
            r_disp        <= 1'b0;
            r_strobe      <= 1'b0;
            for (int i = 0; i < NUM_TASKS; i++) begin
                r_status[i] <= pts_pkg::ST_EMPTY;
            end
        end else begin
            r_state       <= n_state;
            r_slice_ticks <= n_slice_ticks;
            r_tick        <= n_tick;
            r_run_slot    <= n_run_slot;
            r_run_valid   <= n_run_valid;
            r_slice_cnt   <= n_slice_cnt;
            r_switch      <= n_switch;
            r_scan        <= n_scan;
            r_cmp_valid   <= n_cmp_valid;
            r_best_valid  <= n_best_valid;
            r_disp        <= n_disp;
            r_strobe      <= n_strobe;
            r_status      <= n_status;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_func      <= n_func;
        r_id        <= n_id;
        r_prio      <= n_prio;
        r_work      <= n_work;
        r_pend_ev   <= n_pend_ev;
        r_pend_id   <= n_pend_id;
        r_pend_runs <= n_pend_runs;
        r_pend_wait <= n_pend_wait;
        r_pend_sw   <= n_pend_sw;
        r_cmp_idx   <= n_cmp_idx;
        r_best      <= n_best;
        r_best_prio <= n_best_prio;
        r_ent       <= n_ent;
        r_acc       <= n_acc;
        r_disp_runs <= n_disp_runs;
        r_disp_wait <= n_disp_wait;
        r_out_ev    <= n_out_ev;
        r_out_id    <= n_out_id;
        r_out_runs  <= n_out_runs;
        r_out_wait  <= n_out_wait;
        r_out_sw    <= n_out_sw;
        r_out_last  <= n_out_last;
    end

    // ports; the slice length is only taken between commands
    assign busy               = (r_state != pts_pkg::S_IDLE);
    assign o_cfg_ready        = !busy;
    assign o_strobe           = r_strobe;
    assign o_event_res        = r_out_ev;
    assign o_task_id_out      = r_out_id;
    assign o_run_count        = r_out_runs;
    assign o_wait_total       = r_out_wait;
    assign o_context_switches = r_out_sw;
    assign o_last             = r_out_last;

    // checks
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("command transfer did not raise busy");

    a_running_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_valid |-> (r_status[r_run_slot] == pts_pkg::ST_RUN))
        else $error("running slot not marked running");

    a_pair_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |=> (o_strobe && o_last))
        else $error("second result did not follow the first");

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |=> !o_strobe)
        else $error("result transfer after the last one of a command");

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top : self-checking bench for the priority task scheduler
// Drives add, tick, block and unblock commands through the start/busy
// channel, rewrites the slice length between phases, and checks every result
// transfer against a cycle-free model of the task table kept in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

    localparam int NTASK       = 16;
    localparam int N_PHASE     = 8;
    localparam int PHASE_ITEMS = 222;
    localparam int CYCLE_LIMIT = 1000000;

    // One result transfer as seen on the result ports
    typedef struct packed {
        pts_pkg::t_event ev;
        logic [3:0]      id;
        logic [15:0]     runs;
        logic [31:0]     wait_sum;
        logic [31:0]     switches;
        logic            last;
    } t_sched_res;

    // One command, with an optional hand-written first result
    typedef struct packed {
        pts_pkg::t_func  fn;
        logic [3:0]      id;
        logic [7:0]      prio;
        logic [15:0]     work;
        logic            typed;
        pts_pkg::t_event ev;
        logic [3:0]      ev_id;
    } t_cmd_row;

    // DUT connections
    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_func;
    logic [3:0]  i_task_id;
    logic [7:0]  i_priority_req;
    logic [15:0] i_work_ticks;
    logic        o_strobe;
    logic [2:0]  o_event_res;
    logic [3:0]  o_task_id_out;
    logic [15:0] o_run_count;
    logic [31:0] o_wait_total;
    logic [31:0] o_context_switches;
    logic        o_last;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data;

    // Scheduler model state
    pts_pkg::t_status slot_st [NTASK];
    logic [7:0]  slot_prio  [NTASK];
    logic [15:0] slot_total [NTASK];
    logic [15:0] slot_done  [NTASK];
    logic [15:0] slot_runs  [NTASK];
    logic [31:0] slot_wait  [NTASK];
    logic [31:0] slot_stamp [NTASK];
    logic [31:0] now_ticks;
    logic [3:0]  cur_slot;
    logic        cur_valid;
    logic [7:0]  slice_cnt;
    logic [31:0] dispatches;
    logic [7:0]  slice_len;

    t_sched_res  step_res [$];
    t_sched_res  due_res  [$];
    t_cmd_row    dir_rows [$];

    // Bench bookkeeping
    logic            cmd_typed;
    pts_pkg::t_event cmd_ev;
    logic [3:0]      cmd_ev_id;
    bit              gap_on;
    int              n_cmds;
    int              n_cfg;
    int              n_res;
    int              n_err;
    int              ev_seen [8];
    int unsigned     cycles;

    priority_task_scheduler_top #(
        .NUM_TASKS(NTASK)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_func             (i_func),
        .i_task_id          (i_task_id),
        .i_priority_req     (i_priority_req),
        .i_work_ticks       (i_work_ticks),
        .o_strobe           (o_strobe),
        .o_event_res        (o_event_res),
        .o_task_id_out      (o_task_id_out),
        .o_run_count        (o_run_count),
        .o_wait_total       (o_wait_total),
        .o_context_switches (o_context_switches),
        .o_last             (o_last),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_data         (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Scheduler model
    // ------------------------------------------------------------------------

    // statistics of a slot are only reported once it holds a task
    task note_event(input pts_pkg::t_event ev, input logic [3:0] slot);
        t_sched_res r;
        r.ev       = ev;
        r.id       = slot;
        r.runs     = (slot_st[slot] != pts_pkg::ST_EMPTY) ? slot_runs[slot] : 16'd0;
        r.wait_sum = (slot_st[slot] != pts_pkg::ST_EMPTY) ? slot_wait[slot] : 32'd0;
        r.switches = dispatches;
        r.last     = 1'b0;
        step_res   = {step_res, r};
    endtask

    // highest priority ready task, lowest slot on a tie
    task dispatch_next;
        int          best;
        int          i;
        logic [31:0] gap;
        logic [31:0] sum;
        best = -1;
        if (!cur_valid) begin
            for (i = 0; i < NTASK; i++) begin
                if (slot_st[i] == pts_pkg::ST_READY &&
                    (best < 0 || slot_prio[i] > slot_prio[best])) begin
                    best = i;
                end
            end
            if (best >= 0) begin
                if (dispatches != pts_pkg::CNT_MAX)
                    dispatches = dispatches + 32'd1;
                // wait only accrues between successive dispatches
                if (slot_runs[best] != 16'd0) begin
                    gap = now_ticks - slot_stamp[best];
                    sum = slot_wait[best] + gap;
                    slot_wait[best] = (sum < gap) ? pts_pkg::CNT_MAX : sum;
                end
                if (slot_runs[best] != pts_pkg::RUNS_MAX)
                    slot_runs[best] = slot_runs[best] + 16'd1;
                slot_stamp[best] = now_ticks;
                slot_st[best]    = pts_pkg::ST_RUN;
                cur_slot         = best[3:0];
                cur_valid        = 1'b1;
                slice_cnt        = 8'd0;
                note_event(pts_pkg::EV_DISP, best[3:0]);
            end
        end
    endtask

    task sched_step(input pts_pkg::t_func fn, input logic [3:0] id,
                    input logic [7:0] prio, input logic [15:0] work);
        logic [7:0] len;
        case (fn)
            pts_pkg::FN_ADD: begin
                if (slot_st[id] == pts_pkg::ST_EMPTY) begin
                    slot_st[id]    = pts_pkg::ST_READY;
                    slot_prio[id]  = prio;
                    slot_total[id] = work;
                    slot_done[id]  = 16'd0;
                    slot_runs[id]  = 16'd0;
                    slot_wait[id]  = 32'd0;
                    slot_stamp[id] = now_ticks;
                    note_event(pts_pkg::EV_ADD, id);
                end else begin
                    note_event(pts_pkg::EV_REJ, id);
                end
            end
            pts_pkg::FN_TICK: begin
                now_ticks = now_ticks + 32'd1;
                if (cur_valid) begin
                    // a zero slice length behaves as one tick
                    len = (slice_len == 8'd0) ? 8'd1 : slice_len;
                    if (slot_done[cur_slot] < slot_total[cur_slot])
                        slot_done[cur_slot] = slot_done[cur_slot] + 16'd1;
                    if (slice_cnt != pts_pkg::SLICE_MAX)
                        slice_cnt = slice_cnt + 8'd1;
                    if (slot_done[cur_slot] >= slot_total[cur_slot]) begin
                        slot_st[cur_slot] = pts_pkg::ST_DONE;
                        cur_valid = 1'b0;
                        note_event(pts_pkg::EV_FIN, cur_slot);
                    end else if (slice_cnt >= len) begin
                        slot_st[cur_slot] = pts_pkg::ST_READY;
                        cur_valid = 1'b0;
                        note_event(pts_pkg::EV_REQ, cur_slot);
                    end
                end
            end
            pts_pkg::FN_BLOCK: begin
                if (cur_valid) begin
                    slot_st[cur_slot] = pts_pkg::ST_BLOCK;
                    cur_valid = 1'b0;
                    note_event(pts_pkg::EV_BLK, cur_slot);
                end else begin
                    note_event(pts_pkg::EV_REJ, cur_slot);
                end
            end
            default: begin
                if (slot_st[id] == pts_pkg::ST_BLOCK) begin
                    slot_st[id] = pts_pkg::ST_READY;
                    note_event(pts_pkg::EV_UNBLK, id);
                end else begin
                    note_event(pts_pkg::EV_REJ, id);
                end
            end
        endcase
        dispatch_next();
        if (step_res.size() == 0)
            note_event(pts_pkg::EV_NONE, 4'd0);
    endtask

    // ------------------------------------------------------------------------
    // Accept commands, track config writes, check result transfers
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_mon
        t_sched_res got;
        t_sched_res r;
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: run stopped after %0d cycles, %0d results outstanding",
                     $time, cycles, due_res.size());
            $display("priority_task_scheduler_top: mismatch");
            $finish;
        end else if (i_rst_n) begin
            if (start && !busy) begin
                step_res.delete();
                sched_step(pts_pkg::t_func'(i_func), i_task_id, i_priority_req,
                           i_work_ticks);
                // hand-written expectation overrides the model's first event
                if (cmd_typed) begin
                    r = step_res[0];
                    r.ev = cmd_ev;
                    r.id = cmd_ev_id;
                    step_res[0] = r;
                end
                r = step_res[step_res.size() - 1];
                r.last = 1'b1;
                step_res[step_res.size() - 1] = r;
                due_res = {due_res, step_res};
                n_cmds = n_cmds + 1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                slice_len = i_cfg_data;
                n_cfg = n_cfg + 1;
            end
            if (o_strobe) begin
                got = {o_event_res, o_task_id_out, o_run_count, o_wait_total,
                       o_context_switches, o_last};
                n_res = n_res + 1;
                if (due_res.size() == 0) begin
                    n_err = n_err + 1;
                    $display("%0t: unexpected result, expected none, actual ev %0d slot %0d",
                             $time, got.ev, got.id);
                end else begin
                    r = due_res.pop_front();
                    ev_seen[r.ev] = ev_seen[r.ev] + 1;
                    if (got !== r) begin
                        n_err = n_err + 1;
                        $display("%0t: result differs, expected ev %0d slot %0d runs %0d",
                                 $time, r.ev, r.id, r.runs);
                        $display("    wait %0d switches %0d last %0d", r.wait_sum,
                                 r.switches, r.last);
                        $display("    actual ev %0d slot %0d runs %0d wait %0d",
                                 got.ev, got.id, got.runs, got.wait_sum);
                        $display("    switches %0d last %0d", got.switches, got.last);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gap_on || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // hold the command until the transfer has been taken
    task automatic send_cmd(input t_cmd_row c);
        int gap;
        int seen;
        gap = pick_gap();
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start          = 1'b1;
        i_func         = c.fn;
        i_task_id      = c.id;
        i_priority_req = c.prio;
        i_work_ticks   = c.work;
        cmd_typed      = c.typed;
        cmd_ev         = c.ev;
        cmd_ev_id      = c.ev_id;
        seen = n_cmds;
        do @(negedge i_clk); while (n_cmds == seen);
    endtask

    task automatic add_row(input pts_pkg::t_func fn, input logic [3:0] id,
                           input logic [7:0] prio, input logic [15:0] work,
                           input logic typed, input pts_pkg::t_event ev,
                           input logic [3:0] ev_id);
        t_cmd_row c;
        c.fn    = fn;
        c.id    = id;
        c.prio  = prio;
        c.work  = work;
        c.typed = typed;
        c.ev    = ev;
        c.ev_id = ev_id;
        dir_rows = {dir_rows, c};
    endtask

    // slice length only changes with the scheduler idle
    task automatic write_slice(input logic [7:0] v);
        int seen;
        start = 1'b0;
        while (due_res.size() != 0 || busy) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = v;
        seen = n_cfg;
        do @(negedge i_clk); while (n_cfg == seen);
        i_cfg_valid = 1'b0;
    endtask

    // random command; unblocks mostly aim at a blocked slot
    task automatic send_random();
        t_cmd_row c;
        int       r;
        int       i;
        int       blocked [$];
        r = $urandom_range(0, 99);
        c.fn = (r < 40) ? pts_pkg::FN_TICK : (r < 60) ? pts_pkg::FN_ADD :
               (r < 75) ? pts_pkg::FN_BLOCK : pts_pkg::FN_UNBLOCK;
        c.id = 4'($urandom_range(0, 15));
        c.prio = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
        r = $urandom_range(0, 99);
        if (r < 8)
            c.work = 16'd0;
        else if (r < 20)
            c.work = 16'($urandom_range(1, 4));
        else if (r < 28)
            c.work = 16'hFFFF;
        else if (r < 35)
            c.work = 16'($urandom);
        else
            c.work = 16'($urandom_range(5, 150));
        if (c.fn == pts_pkg::FN_UNBLOCK && $urandom_range(0, 3) != 0) begin
            for (i = 0; i < NTASK; i++) begin
                if (slot_st[i] == pts_pkg::ST_BLOCK)
                    blocked = {blocked, i};
            end
            if (blocked.size() > 0)
                c.id = 4'(blocked[$urandom_range(0, blocked.size() - 1)]);
        end
        c.typed = 1'b0;
        c.ev    = pts_pkg::EV_NONE;
        c.ev_id = 4'd0;
        send_cmd(c);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stim
        int         p;
        int         i;
        logic [7:0] v;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_func         = pts_pkg::FN_ADD;
        i_task_id      = 4'd0;
        i_priority_req = 8'd0;
        i_work_ticks   = 16'd0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = 8'd0;
        cmd_typed      = 1'b0;
        cmd_ev         = pts_pkg::EV_NONE;
        cmd_ev_id      = 4'd0;
        gap_on         = 1'b1;
        n_cmds         = 0;
        n_cfg          = 0;
        n_res          = 0;
        n_err          = 0;
        cycles         = 0;
        for (i = 0; i < 8; i++)
            ev_seen[i] = 0;
        for (i = 0; i < NTASK; i++) begin
            slot_st[i]    = pts_pkg::ST_EMPTY;
            slot_prio[i]  = 8'd0;
            slot_total[i] = 16'd0;
            slot_done[i]  = 16'd0;
            slot_runs[i]  = 16'd0;
            slot_wait[i]  = 32'd0;
            slot_stamp[i] = 32'd0;
        end
        now_ticks  = 32'd0;
        cur_slot   = 4'd0;
        cur_valid  = 1'b0;
        slice_cnt  = 8'd0;
        dispatches = 32'd0;
        slice_len  = pts_pkg::SLICE_RESET;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty-table rejects, extremes, ties, zero work, mid-slice frees
        add_row(pts_pkg::FN_BLOCK,   4'd0,  8'd0,   16'd0,    1'b1, pts_pkg::EV_REJ,   4'd0);
        add_row(pts_pkg::FN_TICK,    4'd9,  8'd77,  16'd1234, 1'b1, pts_pkg::EV_NONE,  4'd0);
        add_row(pts_pkg::FN_UNBLOCK, 4'd3,  8'd0,   16'd0,    1'b1, pts_pkg::EV_REJ,   4'd3);
        add_row(pts_pkg::FN_ADD,     4'd15, 8'd255, 16'hFFFF, 1'b1, pts_pkg::EV_ADD,   4'd15);
        add_row(pts_pkg::FN_ADD,     4'd15, 8'd0,   16'd0,    1'b1, pts_pkg::EV_REJ,   4'd15);
        add_row(pts_pkg::FN_ADD,     4'd0,  8'd0,   16'd0,    1'b1, pts_pkg::EV_ADD,   4'd0);
        add_row(pts_pkg::FN_ADD,     4'd1,  8'd255, 16'd2,    1'b1, pts_pkg::EV_ADD,   4'd1);
        add_row(pts_pkg::FN_BLOCK,   4'd5,  8'd1,   16'd1,    1'b1, pts_pkg::EV_BLK,   4'd15);
        add_row(pts_pkg::FN_TICK,    4'd0,  8'd0,   16'd0,    1'b0, pts_pkg::EV_NONE,  4'd0);
        add_row(pts_pkg::FN_TICK,    4'd0,  8'd0,   16'd0,    1'b1, pts_pkg::EV_FIN,   4'd1);
        add_row(pts_pkg::FN_TICK,    4'd0,  8'd0,   16'd0,    1'b1, pts_pkg::EV_FIN,   4'd0);
        add_row(pts_pkg::FN_UNBLOCK, 4'd15, 8'd0,   16'd0,    1'b1, pts_pkg::EV_UNBLK, 4'd15);
        add_row(pts_pkg::FN_UNBLOCK, 4'd15, 8'd0,   16'd0,    1'b1, pts_pkg::EV_REJ,   4'd15);
        add_row(pts_pkg::FN_ADD,     4'd1,  8'd9,   16'd9,    1'b1, pts_pkg::EV_REJ,   4'd1);
        for (i = 0; i < 5; i++)
            add_row(pts_pkg::FN_TICK, 4'd0, 8'd0, 16'd0, 1'b0, pts_pkg::EV_NONE, 4'd0);
        add_row(pts_pkg::FN_ADD,     4'd7,  8'd128, 16'd1,    1'b0, pts_pkg::EV_NONE,  4'd0);
        add_row(pts_pkg::FN_ADD,     4'd8,  8'd128, 16'd1,    1'b0, pts_pkg::EV_NONE,  4'd0);
        add_row(pts_pkg::FN_BLOCK,   4'd0,  8'd0,   16'd0,    1'b0, pts_pkg::EV_NONE,  4'd0);
        add_row(pts_pkg::FN_TICK,    4'd0,  8'd0,   16'd0,    1'b0, pts_pkg::EV_NONE,  4'd0);
        add_row(pts_pkg::FN_TICK,    4'd0,  8'd0,   16'd0,    1'b0, pts_pkg::EV_NONE,  4'd0);
        add_row(pts_pkg::FN_UNBLOCK, 4'd15, 8'd0,   16'd0,    1'b0, pts_pkg::EV_NONE,  4'd0);
        foreach (dir_rows[k])
            send_cmd(dir_rows[k]);

        // random phases, each under its own slice length
        for (p = 0; p < N_PHASE; p++) begin
            case (p)
                0: v = 8'd1;
                1: v = pts_pkg::SLICE_MAX;
                2: v = 8'd0;
                3: v = 8'd2;
                4: v = 8'($urandom_range(1, 255));
                5: v = 8'd3;
                6: v = 8'd8;
                default: v = pts_pkg::SLICE_RESET;
            endcase
            write_slice(v);
            gap_on = (p != 2 && p != 5);
            repeat (PHASE_ITEMS) send_random();
        end

        // drain
        start = 1'b0;
        while (due_res.size() != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);

        $display("covered %0d commands, %0d result transfers, %0d slice settings",
                 n_cmds, n_res, n_cfg);
        $display("events: %0d dispatch %0d requeue %0d finish %0d block %0d unblock %0d reject",
                 ev_seen[pts_pkg::EV_DISP], ev_seen[pts_pkg::EV_REQ],
                 ev_seen[pts_pkg::EV_FIN], ev_seen[pts_pkg::EV_BLK],
                 ev_seen[pts_pkg::EV_UNBLK], ev_seen[pts_pkg::EV_REJ]);
        if (n_err == 0) begin
            $display("priority_task_scheduler_top: match");
        end else begin
            $display("priority_task_scheduler_top: mismatch");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/pts_pkg.sv
design/pts_ram.sv
design/pts_alu.sv
design/priority_task_scheduler_top.sv
sim/tb_top.sv
